// File: rtl/radio_link_fault_supervisor_macros.svh
// assertion macros for the radio link fault supervisor
// used by files that carry concurrent assertions; no other dependencies
`ifndef RADIO_LINK_FAULT_SUPERVISOR_MACROS_SVH
`define RADIO_LINK_FAULT_SUPERVISOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define RLFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rlfs assertion failed");

// next-cycle implication, checked outside reset
`define RLFS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlfs assertion failed");

`endif

// File: rtl/rlfs_pkg.sv
// shared types and constants for the radio link fault supervisor
// no dependencies
`default_nettype none

package rlfs_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int CFG_W      = 32;
  localparam int CMP_W      = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;
  localparam int CNT_W      = 32;
  localparam int THR_W      = 8;
  localparam int STATE_W    = 3;
  localparam int CFG_IDX_W  = 2;

  // raw radio state codes
  localparam logic [STATE_W-1:0] RADIO_NONE          = 3'd0;
  localparam logic [STATE_W-1:0] RADIO_BAD_MESSAGE   = 3'd1;
  localparam logic [STATE_W-1:0] RADIO_UDP_CONNECTED = 3'd6;
  localparam logic [STATE_W-1:0] RADIO_UNKNOWN       = 3'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HB_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TELEM_IVAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_THRESH  = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0] HB_TIMEOUT_RST = 32'd30000;
  localparam logic [CFG_W-1:0] TELEM_IVAL_RST = 32'd1000;
  localparam logic [THR_W-1:0] ESC_THRESH_RST = 8'd3;

  localparam logic [THR_W-1:0] RESET_CNT_MAX = {THR_W{1'b1}};

  typedef struct packed {
    logic [CFG_W-1:0] hb_timeout;
    logic [CFG_W-1:0] telem_ival;
    logic [THR_W-1:0] esc_thresh;
  } cfg_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] now_ms;
    logic [STATE_W-1:0]    radio_state;
    logic [CNT_W-1:0]      rx_packets;
    logic [CNT_W-1:0]      tx_packets;
    logic [TIME_WIDTH-1:0] heartbeat_ms;
    logic                  critical_failure;
  } item_t;

  typedef struct packed {
    logic [STATE_W-1:0] link_state;
    logic               state_changed;
    logic               telemetry_due;
    logic               reset_radio;
    logic               reset_host;
    logic               clear_critical;
  } result_t;

  typedef struct packed {
    logic [STATE_W-1:0]    reported_state;
    logic                  first_tick;
    logic [TIME_WIDTH-1:0] last_report_ms;
    logic [THR_W-1:0]      reset_cnt;
    logic [CNT_W-1:0]      rx_at_reset;
    logic [CNT_W-1:0]      tx_at_reset;
  } sup_state_t;

endpackage

`default_nettype wire

// File: rtl/rlfs_eval.sv
// per-tick decision logic: state mapping, telemetry timer, fault escalation
// depends on rlfs_pkg
`default_nettype none

module rlfs_eval import rlfs_pkg::*; (
  input  item_t      item,
  input  cfg_t       cfg,
  input  sup_state_t st,
  output result_t    res,
  output sup_state_t st_nxt
);

  logic [STATE_W-1:0]    link;
  logic [TIME_WIDTH-1:0] telem_diff;
  logic [TIME_WIDTH-1:0] hb_diff;
  logic                  telem;
  logic                  good_link;
  logic [THR_W-1:0]      cnt_mid;
  logic                  fault;
  logic                  allow_radio;
  logic                  rr;
  logic                  rh;

  always_comb begin
    link = (item.radio_state == RADIO_UNKNOWN) ? RADIO_BAD_MESSAGE : item.radio_state;

    // wrapping time differences
    telem_diff = item.now_ms - st.last_report_ms;
    hb_diff    = item.now_ms - item.heartbeat_ms;
    telem      = CMP_W'(telem_diff) >= CMP_W'(cfg.telem_ival);

    // link proven healthy since last radio reset
    good_link = (item.radio_state == RADIO_UDP_CONNECTED) &&
                (item.rx_packets > st.rx_at_reset) &&
                (item.tx_packets > st.tx_at_reset);
    cnt_mid   = good_link ? '0 : st.reset_cnt;

    fault       = item.critical_failure || (CMP_W'(hb_diff) > CMP_W'(cfg.hb_timeout));
    allow_radio = cnt_mid <= cfg.esc_thresh;
    rr          = fault && allow_radio;
    rh          = fault && !allow_radio;

    res.link_state     = link;
    res.state_changed  = st.first_tick || (st.reported_state != link);
    res.telemetry_due  = telem;
    res.reset_radio    = rr;
    res.reset_host     = rh;
    res.clear_critical = fault;

    st_nxt.reported_state = link;
    st_nxt.first_tick     = 1'b0;
    st_nxt.last_report_ms = telem ? item.now_ms : st.last_report_ms;
    if (rr && (cnt_mid != RESET_CNT_MAX)) begin
      st_nxt.reset_cnt = cnt_mid + THR_W'(1);
    end else begin
      st_nxt.reset_cnt = cnt_mid;
    end
    st_nxt.rx_at_reset = rr ? item.rx_packets : st.rx_at_reset;
    st_nxt.tx_at_reset = rr ? item.tx_packets : st.tx_at_reset;
  end

endmodule

`default_nettype wire

// File: rtl/radio_link_fault_supervisor.sv
// radio link fault supervisor, top level: input register, decision logic, result register
// depends on rlfs_pkg, rlfs_eval and radio_link_fault_supervisor_macros.svh
//
// usage
//   one in_ transaction is one scheduler tick; each tick gives exactly one
//   out_ transaction carrying the mapped link state and the report and reset flags
//   cfg_ writes set the heartbeat timeout, telemetry interval and escalation
//   threshold; cfg_ready is always high, index 3 is ignored; write only when idle
//   latency: a tick accepted at edge n shows its result on out_ after edge n+1
//   throughput: one tick per cycle, set by the single decision stage that reads
//   and updates the supervisor state in the same cycle
//   stall: while out_ready is low the result register holds, the decision stage
//   waits, and the input register still takes one more tick before in_ready drops
//   reset (rst_n low, synchronous): pipeline empties, config returns to defaults,
//   the reset counter and packet snapshots clear and the first-tick flag is set
`default_nettype none
`include "radio_link_fault_supervisor_macros.svh"

module radio_link_fault_supervisor import rlfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  // tick input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TIME_WIDTH-1:0] in_now_ms,
  input  logic [STATE_W-1:0]    in_radio_state,
  input  logic [CNT_W-1:0]      in_rx_packets,
  input  logic [CNT_W-1:0]      in_tx_packets,
  input  logic [TIME_WIDTH-1:0] in_heartbeat_ms,
  input  logic                  in_critical_failure,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATE_W-1:0]    out_link_state,
  output logic                  out_state_changed,
  output logic                  out_telemetry_due,
  output logic                  out_reset_radio,
  output logic                  out_reset_host,
  output logic                  out_clear_critical
);

  cfg_t       cfg_r;
  item_t      item_r;
  logic       item_valid_r;
  sup_state_t st_r;
  sup_state_t st_nxt;
  result_t    res_nxt;
  result_t    res_r;
  logic       res_valid_r;
  logic       advance;
  logic       in_fire;

  // config writes land immediately
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hb_timeout <= HB_TIMEOUT_RST;
      cfg_r.telem_ival <= TELEM_IVAL_RST;
      cfg_r.esc_thresh <= ESC_THRESH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HB_TIMEOUT: cfg_r.hb_timeout <= cfg_data;
        REG_TELEM_IVAL: cfg_r.telem_ival <= cfg_data;
        REG_ESC_THRESH: cfg_r.esc_thresh <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // decision stage moves when the result register is free or being drained
  assign advance  = item_valid_r && (!res_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.now_ms           <= in_now_ms;
      item_r.radio_state      <= in_radio_state;
      item_r.rx_packets       <= in_rx_packets;
      item_r.tx_packets       <= in_tx_packets;
      item_r.heartbeat_ms     <= in_heartbeat_ms;
      item_r.critical_failure <= in_critical_failure;
    end
  end

  rlfs_eval u_eval (
    .item   (item_r),
    .cfg    (cfg_r),
    .st     (st_r),
    .res    (res_nxt),
    .st_nxt (st_nxt)
  );

  // supervisor state updates once per processed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.reported_state <= RADIO_NONE;
      st_r.first_tick     <= 1'b1;
      st_r.last_report_ms <= '0;
      st_r.reset_cnt      <= '0;
      st_r.rx_at_reset    <= '0;
      st_r.tx_at_reset    <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (out_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = res_valid_r;
  assign out_link_state     = res_r.link_state;
  assign out_state_changed  = res_r.state_changed;
  assign out_telemetry_due  = res_r.telemetry_due;
  assign out_reset_radio    = res_r.reset_radio;
  assign out_reset_host     = res_r.reset_host;
  assign out_clear_critical = res_r.clear_critical;

  // radio and host reset requests are exclusive
  `RLFS_ASSERT_IMP(a_one_reset_kind, clk, rst_n, res_valid_r, !(res_r.reset_radio && res_r.reset_host))
  // a handled fault always comes with exactly one reset request
  `RLFS_ASSERT_IMP(a_clear_matches, clk, rst_n, res_valid_r, res_r.clear_critical == (res_r.reset_radio || res_r.reset_host))
  // a pending radio reset result means the reset counter is nonzero
  `RLFS_ASSERT_IMP(a_cnt_bumped, clk, rst_n, res_valid_r && res_r.reset_radio, st_r.reset_cnt != '0)
  // an unchanged-state report can only follow the first tick
  `RLFS_ASSERT_IMP(a_first_done, clk, rst_n, res_valid_r && !res_r.state_changed, !st_r.first_tick)

endmodule

`default_nettype wire
